// ===== rtl/wfbo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfbo_pkg
// shared types and codes for the word fifo with block or overwrite policy
// ----------------------------------------------------------------------------
package wfbo_pkg;

	localparam int OP_W   = 2;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 9;
	localparam int CFG_W  = 9;
	localparam int CIDX_W = 1;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CIDX_W-1:0] REG_FULL_POLICY = 1'd0;
	localparam logic [CIDX_W-1:0] REG_CAPACITY    = 1'd1;

	localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

	// status of one finished request, handed from control to the top level
	typedef struct packed {
		logic             success;
		logic             rd_hit;
		logic             dropped;
		logic [CNT_W-1:0] occ;
		logic [CNT_W-1:0] free;
	} res_stat_t;

endpackage
`default_nettype wire

// ===== rtl/wfbo_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfbo_ctrl
// pointer, count and config registers; issues at most one memory access per request
// ----------------------------------------------------------------------------
module wfbo_ctrl #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               acc,
	input  wire  [wfbo_pkg::OP_W-1:0]         opcode,
	input  wire                               cfg_we,
	input  wire  [wfbo_pkg::CIDX_W-1:0]       cfg_index,
	input  wire  [wfbo_pkg::CFG_W-1:0]        cfg_data,
	output logic                              mem_we,
	output logic [IDX_W-1:0]                  mem_waddr,
	output logic                              mem_re,
	output logic [IDX_W-1:0]                  mem_raddr,
	output logic                              res_vld_q,
	output wfbo_pkg::res_stat_t               res_q
);

	localparam int CW    = wfbo_pkg::CNT_W;
	localparam int CMP_W = (IDX_W >= CW) ? IDX_W + 1 : CW;

	logic [IDX_W-1:0] head_q, tail_q;
	logic [CW-1:0]    cnt_q;
	logic             policy_q;
	logic [CW-1:0]    cap_q;

	logic [CW-1:0]    cap_eff;
	logic             full;
	logic [IDX_W-1:0] head_nx, tail_nx, head_adv, tail_adv;
	logic [CW-1:0]    cnt_nx;
	logic             ok, drop, rd_hit;

	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
	                                         input logic [CW-1:0] cap);
		logic [CMP_W-1:0] n;
		n = CMP_W'(idx) + CMP_W'(1);
		return (n >= CMP_W'(cap)) ? IDX_W'(0) : n[IDX_W-1:0];
	endfunction

	// capacity zero acts as one, capacity beyond the built depth as the depth
	always_comb begin
		if (cap_q == '0)
			cap_eff = CW'(1);
		else if (32'(cap_q) > 32'(DEPTH))
			cap_eff = CW'(DEPTH);
		else
			cap_eff = cap_q;
	end

	assign full     = (cnt_q >= cap_eff);
	assign head_adv = adv(head_q, cap_eff);
	assign tail_adv = adv(tail_q, cap_eff);

	always_comb begin
		head_nx = head_q;
		tail_nx = tail_q;
		cnt_nx  = cnt_q;
		ok      = 1'b0;
		drop    = 1'b0;
		rd_hit  = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		unique case (opcode)
			wfbo_pkg::OP_WRITE: begin
				if (!full || policy_q) begin
					ok      = 1'b1;
					mem_we  = acc;
					tail_nx = tail_adv;
					if (full) begin
						// overwrite: oldest slides out, count stays
						head_nx = head_adv;
						drop    = 1'b1;
					end else begin
						cnt_nx = cnt_q + CW'(1);
					end
				end
			end
			wfbo_pkg::OP_READ: begin
				if (cnt_q != '0) begin
					ok      = 1'b1;
					rd_hit  = 1'b1;
					mem_re  = acc;
					head_nx = head_adv;
					cnt_nx  = cnt_q - CW'(1);
				end
			end
			wfbo_pkg::OP_CLEAR: begin
				ok      = 1'b1;
				head_nx = '0;
				tail_nx = '0;
				cnt_nx  = '0;
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = tail_q;
	assign mem_raddr = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			policy_q  <= 1'b0;
			cap_q     <= wfbo_pkg::CAP_RESET;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= acc;
			if (cfg_we) begin
				unique case (cfg_index)
					wfbo_pkg::REG_FULL_POLICY: policy_q <= cfg_data[0];
					wfbo_pkg::REG_CAPACITY: begin
						cap_q  <= cfg_data;
						head_q <= '0;
						tail_q <= '0;
						cnt_q  <= '0;
					end
					default: begin
					end
				endcase
			end else if (acc) begin
				head_q <= head_nx;
				tail_q <= tail_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.success <= ok;
			res_q.rd_hit  <= rd_hit;
			res_q.dropped <= drop;
			res_q.occ     <= cnt_nx;
			res_q.free    <= (cnt_nx >= cap_eff) ? '0 : (cap_eff - cnt_nx);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/word_fifo_block_or_overwrite_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// word_fifo_block_or_overwrite_core
// circular fifo of 32-bit words, software capacity, refuse or overwrite when full
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+---------------------------------
//  request   | start, busy (taken: start&!busy) | opcode, write_word
//  result    | result_valid (one cycle)      | success, read_word, dropped_oldest,
//            |                               | occupancy, free_space
//  config    | cfg_we                        | cfg_index, cfg_data
//
//  - a request may be issued every cycle once busy is low; its result appears on the cycle
//    after it is taken, so throughput is one per cycle
//  - the single-port-write, single-port-read word memory is the only storage;
//    a write updates the entry at the taken edge, a read registers the data
//    at the same edge, so a read right after a write sees the new word
//  - busy is high only in the first cycle after reset; no clearing pass is
//    needed since entries are only read after being written
//  - the receiver cannot stall: each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module word_fifo_block_or_overwrite_core #(
	parameter int DEPTH = 256
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  [wfbo_pkg::OP_W-1:0]       opcode,
	input  wire  [wfbo_pkg::WORD_W-1:0]     write_word,
	output logic                            result_valid,
	output logic                            success,
	output logic [wfbo_pkg::WORD_W-1:0]     read_word,
	output logic                            dropped_oldest,
	output logic [wfbo_pkg::CNT_W-1:0]      occupancy,
	output logic [wfbo_pkg::CNT_W-1:0]      free_space,
	input  wire                             cfg_we,
	input  wire  [wfbo_pkg::CIDX_W-1:0]     cfg_index,
	input  wire  [wfbo_pkg::CFG_W-1:0]      cfg_data
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                        busy_q;
	logic                        acc;
	logic                        mem_we, mem_re;
	logic [IDX_W-1:0]            mem_waddr, mem_raddr;
	logic                        res_vld;
	wfbo_pkg::res_stat_t         res;

	// word storage, one write and one registered read per cycle
	logic [wfbo_pkg::WORD_W-1:0] mem [DEPTH];
	logic [wfbo_pkg::WORD_W-1:0] rdata_q;

	// held off for the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	assign busy = busy_q;
	assign acc  = start && !busy_q;

	wfbo_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.opcode    (opcode),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res_vld_q (res_vld),
		.res_q     (res)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= write_word;
	end

	always_ff @(posedge clk) begin
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	// result fields straight from the result register; word zero unless a read hit
	assign result_valid   = res_vld;
	assign success        = res.success;
	assign read_word      = res.rd_hit ? rdata_q : '0;
	assign dropped_oldest = res.dropped;
	assign occupancy      = res.occ;
	assign free_space     = res.free;

`ifndef SYNTHESIS
	a_res_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy))
		else $error("result without a taken request");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && dropped_oldest) |-> (success && free_space == '0))
		else $error("drop reported while not full");

	a_word_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && read_word != '0) |-> (success && !dropped_oldest))
		else $error("read word on a step that was not a read");

	a_read_en: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res.rd_hit) |-> $past(mem_re && !mem_we))
		else $error("read hit without a memory read");
`endif

endmodule
`default_nettype wire
